// ===== rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Types and constants for the character LCD nibble expander encoder.
// ----------------------------------------------------------------------------
package cle_pkg;

   typedef enum logic [2:0] {
      OP_INIT        = 3'd0,
      OP_PUT_CHAR    = 3'd1,
      OP_GOTO        = 3'd2,
      OP_CURSOR      = 3'd3,
      OP_SHIFT_RIGHT = 3'd4,
      OP_SHIFT_LEFT  = 3'd5,
      OP_SHIFT_STOP  = 3'd6,
      OP_RAW         = 3'd7
   } op_type;

   typedef struct packed {
      op_type     opcode;
      logic [7:0] char_code;
      logic [5:0] column;
      logic       row;
      logic       cursor_on;
      logic       register_select;
   } req_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       long_wait;
      logic       last;
   } rsp_type;

   // One LCD byte as handed from the front part to the back part.
   typedef struct packed {
      logic [7:0] data;
      logic       rs;
      logic       slow;
      logic       final_byte;
   } lcd_byte_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int         INIT_LEN = 5;
   localparam logic [2:0] INIT_LAST = 3'(INIT_LEN - 1);
   localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{8'h02, 8'h28, 8'h0C, 8'h01, 8'h06};

   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_SHIFT_RIGHT = 8'b0001_1100;
   localparam logic [7:0] CMD_SHIFT_LEFT  = 8'b0001_1000;
   localparam logic [7:0] CMD_SHIFT_STOP  = 8'b0001_0000;
   localparam logic [7:0] CMD_ROW1_HOME   = 8'hC0;
   localparam logic [7:0] CHAR_FORM_FEED  = 8'h0C;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;

endpackage

// ===== rtl/cle_front.sv =====
// ----------------------------------------------------------------------------
// cle_front
// Accepts requests and expands each into its LCD bytes, one per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module cle_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  cle_pkg::req_type     req_data,
   output logic                 q_push,
   input  logic                 q_full,
   output cle_pkg::lcd_byte_type q_data
);
   import cle_pkg::*;

   req_type      req_ff, req_in;
   logic         busy_ff, busy_in;
   logic [2:0]   idx_ff, idx_in;
   lcd_byte_type lcd;
   logic         take_next;
   logic         accept;

   always_comb begin
      lcd.rs         = 1'b0;
      lcd.data       = 8'h00;
      lcd.final_byte = 1'b1;
      unique case (req_ff.opcode)
         OP_INIT: begin
            lcd.data       = INIT_SEQ[idx_ff];
            lcd.final_byte = (idx_ff == INIT_LAST);
         end
         OP_PUT_CHAR: begin
            if (req_ff.char_code == CHAR_FORM_FEED) begin
               lcd.data = CMD_CLEAR;
            end else if (req_ff.char_code == CHAR_NEWLINE) begin
               lcd.data = CMD_ROW1_HOME;
            end else begin
               lcd.data = req_ff.char_code;
               lcd.rs   = 1'b1;
            end
         end
         OP_GOTO:        lcd.data = {1'b1, req_ff.row, req_ff.column};
         OP_CURSOR:      lcd.data = CMD_DISPLAY_ON | {6'd0, req_ff.cursor_on, 1'b0};
         OP_SHIFT_RIGHT: lcd.data = CMD_SHIFT_RIGHT;
         OP_SHIFT_LEFT:  lcd.data = CMD_SHIFT_LEFT;
         OP_SHIFT_STOP:  lcd.data = CMD_SHIFT_STOP;
         OP_RAW: begin
            lcd.data = req_ff.char_code;
            lcd.rs   = req_ff.register_select;
         end
         default: lcd.data = 8'h00;
      endcase
      // clear and home commands need the long wait
      lcd.slow = !lcd.rs && (lcd.data == CMD_CLEAR || lcd.data[7:1] == 7'b0000001);
   end

   always_comb begin
      q_data    = lcd;
      q_push    = busy_ff && !q_full;
      take_next = !busy_ff || (q_push && lcd.final_byte);
      req_full  = !take_next;
      accept    = req_push && take_next;
      req_in    = accept ? req_data : req_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      if (q_push) begin
         idx_in = lcd.final_byte ? 3'd0 : idx_ff + 3'd1;
         if (lcd.final_byte) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= INIT_LAST)
      else $error("init step index out of range");

   a_idx_only_init: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 3'd0 |-> busy_ff && req_ff.opcode == OP_INIT)
      else $error("step index moved outside an init request");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !q_push |-> req_full)
      else $error("request taken while the current one is stalled");

endmodule

// ===== rtl/cle_queue.sv =====
// ----------------------------------------------------------------------------
// cle_queue
// Short queue of LCD bytes between the front and back parts.
// ----------------------------------------------------------------------------
module cle_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  cle_pkg::lcd_byte_type push_data,
   input  logic                  pop,
   output logic                  empty,
   output cle_pkg::lcd_byte_type pop_data
);
   import cle_pkg::*;

   lcd_byte_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;

   always_comb begin
      full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      pop_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count over depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

// ===== rtl/cle_back.sv =====
// ----------------------------------------------------------------------------
// cle_back
// Splits each LCD byte into four expander bytes, one per result.
// ----------------------------------------------------------------------------
module cle_back (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  q_pop,
   input  logic                  q_empty,
   input  cle_pkg::lcd_byte_type q_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output cle_pkg::rsp_type      rsp_data
);
   import cle_pkg::*;

   lcd_byte_type cur_ff, cur_in;
   logic         valid_ff, valid_in;
   logic [1:0]   phase_ff, phase_in;
   logic         done;
   logic [3:0]   nib;

   always_comb begin
      done      = valid_ff && rsp_pop && (phase_ff == 2'd3);
      q_pop     = (!valid_ff || done) && !q_empty;
      cur_in    = q_pop ? q_data : cur_ff;
      valid_in  = valid_ff;
      phase_in  = phase_ff;
      if (!valid_ff || done) begin
         valid_in = !q_empty;
         phase_in = 2'd0;
      end else if (rsp_pop) begin
         phase_in = phase_ff + 2'd1;
      end

      // high nibble first, enable pulses high then low
      nib                    = phase_ff[1] ? cur_ff.data[3:0] : cur_ff.data[7:4];
      rsp_empty              = !valid_ff;
      rsp_data.expander_byte = {nib, 1'b1, !phase_ff[0], 1'b0, cur_ff.rs};
      rsp_data.long_wait     = cur_ff.slow && (phase_ff == 2'd3);
      rsp_data.last          = cur_ff.final_byte && (phase_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> phase_ff == 2'd0)
      else $error("phase moved without a byte");

   a_step: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_pop && phase_ff != 2'd3 |=> valid_ff && phase_ff == $past(phase_ff) + 2'd1)
      else $error("expander byte sequence broken");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_pop |=> valid_ff && $stable(phase_ff) && $stable(cur_ff))
      else $error("result changed while stalled");

endmodule

// ===== rtl/char_lcd_nibble_expander_encoder.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_expander_encoder
// Turns display requests into expander bytes for a 4-bit character LCD.
// ----------------------------------------------------------------------------
// The first expander byte of a request passes the front request register, the queue
// and the back byte register. Throughput: one expander byte per cycle while rsp_pop
// is high, set by the back nibble splitter; one LCD byte per request (five for init).
// Requests are taken while earlier bytes still drain through the 4-entry queue.
// Reset (synchronous) empties the queue and drops any request in progress.
module char_lcd_nibble_expander_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cle_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cle_pkg::rsp_type  rsp_data
);
   import cle_pkg::*;

   logic         q_push, q_full, q_pop, q_empty;
   lcd_byte_type q_push_data, q_pop_data;

   cle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_push_data)
   );

   cle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_push_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   cle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_pop     (q_pop),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
